/* sv/lfss_pkg.sv */
`timescale 1ns / 1ps

package lfss_pkg;

  // grid limits
  localparam int MAX_WIDTH = 1024;
  localparam int MAX_ROWS  = 1024;

  // field widths
  localparam int SYM_W  = 8;
  localparam int SIZE_W = 11;
  localparam int COL_W  = 10;
  localparam int ROW_W  = 10;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;
  localparam int OUT_DATA_W = 32;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_WIDTH       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OBSTACLE_SYMBOL = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_EMPTY_SYMBOL    = 2'd2;

  // configuration reset values
  localparam logic [SIZE_W-1:0] ROW_WIDTH_RST       = SIZE_W'(MAX_WIDTH);
  localparam logic [SYM_W-1:0]  OBSTACLE_SYMBOL_RST = 8'd111;
  localparam logic [SYM_W-1:0]  EMPTY_SYMBOL_RST    = 8'd46;

  // smallest of three square sides
  function automatic logic [SIZE_W-1:0] min3(input logic [SIZE_W-1:0] a,
                                             input logic [SIZE_W-1:0] b,
                                             input logic [SIZE_W-1:0] c);
    logic [SIZE_W-1:0] m;
    m = (a < b) ? a : b;
    return (m < c) ? m : c;
  endfunction

endpackage

/* sv/largest_free_square_scan_top.sv */
// a result is registered: the last cell passes the processing stage, then the result register drives out_tvalid
// throughput: one cell per cycle, set by the single line buffer read issued at acceptance
// a stalled result holds back only the stage behind it; cells keep flowing otherwise
// reset (rst_n low, synchronous) clears counters, tracking and handshake state and loads
// the configuration defaults; the line buffer is not cleared and needs no clearing pass
`timescale 1ns / 1ps

module largest_free_square_scan_top (
  input  logic                               clk,
  input  logic                               rst_n,
  // input cells
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [lfss_pkg::SYM_W-1:0]         in_tdata,   // [7:0] cell_symbol
  input  logic                               in_tlast,   // end_of_grid
  // results
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [lfss_pkg::OUT_DATA_W-1:0]    out_tdata,  // [10:0] best_size, [20:11] best_row,
                                                         // [30:21] best_col, [31] zero
  // configuration writes
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [lfss_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [lfss_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int SIZE_W = lfss_pkg::SIZE_W;
  localparam int COL_W  = lfss_pkg::COL_W;
  localparam int ROW_W  = lfss_pkg::ROW_W;
  localparam int SYM_W  = lfss_pkg::SYM_W;

  // configuration registers
  logic [SIZE_W-1:0] row_width_r;
  logic [SYM_W-1:0]  obstacle_symbol_r;
  logic [SYM_W-1:0]  empty_symbol_r;

  // scan position of the next accepted cell
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;

  // line buffer and its registered read
  logic [SIZE_W-1:0] line_mem [lfss_pkg::MAX_WIDTH];
  logic [SIZE_W-1:0] up_r;

  // processing stage
  logic              s1_v_r;
  logic [SYM_W-1:0]  s1_sym_r;
  logic              s1_last_r;
  logic              s1_wrap_r;
  logic [COL_W-1:0]  s1_col_r;
  logic [ROW_W-1:0]  s1_row_r;

  // running square state
  logic [SIZE_W-1:0] left_r, left_nxt;
  logic [SIZE_W-1:0] diag_r, diag_nxt;
  logic [SIZE_W-1:0] max_side_r, max_side_nxt;
  logic [ROW_W-1:0]  max_row_r, max_row_nxt;
  logic [COL_W-1:0]  max_col_r, max_col_nxt;

  // result register
  logic              out_valid_r;
  logic [SIZE_W-1:0] out_size_r;
  logic [ROW_W-1:0]  out_row_r;
  logic [COL_W-1:0]  out_col_r;

  logic              in_accept;
  logic              s1_fire;
  logic [SIZE_W-1:0] used_width;
  logic              wrap;
  logic              is_free;
  logic [SIZE_W-1:0] cell_val;

  // configuration port is always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_width_r       <= lfss_pkg::ROW_WIDTH_RST;
      obstacle_symbol_r <= lfss_pkg::OBSTACLE_SYMBOL_RST;
      empty_symbol_r    <= lfss_pkg::EMPTY_SYMBOL_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        lfss_pkg::CFG_ROW_WIDTH:       row_width_r       <= cfg_data;
        lfss_pkg::CFG_OBSTACLE_SYMBOL: obstacle_symbol_r <= cfg_data[SYM_W-1:0];
        lfss_pkg::CFG_EMPTY_SYMBOL:    empty_symbol_r    <= cfg_data[SYM_W-1:0];
        default: ;
      endcase
    end
  end

  // handshake between the stages
  assign s1_fire   = s1_v_r && (!s1_last_r || !out_valid_r || out_tready);
  assign in_tready = !s1_v_r || s1_fire;
  assign in_accept = in_tvalid && in_tready;

  // clamp the row width to 1..MAX_WIDTH
  always_comb begin
    if (row_width_r == '0) begin
      used_width = SIZE_W'(1);
    end else if (row_width_r > SIZE_W'(lfss_pkg::MAX_WIDTH)) begin
      used_width = SIZE_W'(lfss_pkg::MAX_WIDTH);
    end else begin
      used_width = row_width_r;
    end
  end

  assign wrap = ({1'b0, col_r} + SIZE_W'(1)) >= used_width;

  // advance the scan position
  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (in_accept) begin
      if (in_tlast) begin
        col_nxt = '0;
        row_nxt = '0;
      end else if (wrap) begin
        col_nxt = '0;
        if (row_r != ROW_W'(lfss_pkg::MAX_ROWS - 1)) begin
          row_nxt = row_r + ROW_W'(1);
        end
      end else begin
        col_nxt = col_r + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // load the processing stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_accept) begin
      s1_v_r <= 1'b1;
    end else if (s1_fire) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_sym_r  <= in_tdata;
      s1_last_r <= in_tlast;
      s1_wrap_r <= wrap;
      s1_col_r  <= col_r;
      s1_row_r  <= row_r;
    end
  end

  // line buffer: read ahead at acceptance, write back when the cell retires
  always_ff @(posedge clk) begin
    if (in_accept) begin
      up_r <= line_mem[col_r];
    end
    if (s1_fire) begin
      line_mem[s1_col_r] <= cell_val;
    end
  end

  // square side ending at this cell
  assign is_free = (s1_sym_r != obstacle_symbol_r) && (s1_sym_r == empty_symbol_r);

  always_comb begin
    cell_val = '0;
    if (is_free) begin
      if (s1_row_r == '0 || s1_col_r == '0) begin
        cell_val = SIZE_W'(1);
      end else begin
        cell_val = lfss_pkg::min3(up_r, left_r, diag_r) + SIZE_W'(1);
      end
    end
  end

  // neighbor values and best square tracking
  always_comb begin
    left_nxt     = left_r;
    diag_nxt     = diag_r;
    max_side_nxt = max_side_r;
    max_row_nxt  = max_row_r;
    max_col_nxt  = max_col_r;
    if (s1_fire) begin
      if (cell_val > max_side_r) begin
        max_side_nxt = cell_val;
        max_row_nxt  = s1_row_r;
        max_col_nxt  = s1_col_r;
      end
      if (s1_wrap_r) begin
        left_nxt = '0;
        diag_nxt = '0;
      end else begin
        left_nxt = cell_val;
        diag_nxt = up_r;
      end
      if (s1_last_r) begin
        left_nxt     = '0;
        diag_nxt     = '0;
        max_side_nxt = '0;
        max_row_nxt  = '0;
        max_col_nxt  = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r     <= '0;
      diag_r     <= '0;
      max_side_r <= '0;
      max_row_r  <= '0;
      max_col_r  <= '0;
    end else begin
      left_r     <= left_nxt;
      diag_r     <= diag_nxt;
      max_side_r <= max_side_nxt;
      max_row_r  <= max_row_nxt;
      max_col_r  <= max_col_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire && s1_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_last_r) begin
      if (cell_val > max_side_r) begin
        out_size_r <= cell_val;
        out_row_r  <= s1_row_r;
        out_col_r  <= s1_col_r;
      end else begin
        out_size_r <= max_side_r;
        out_row_r  <= max_row_r;
        out_col_r  <= max_col_r;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_col_r, out_row_r, out_size_r};

  // a held result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_tready |-> !(s1_fire && s1_last_r))
    else $error("result register overwritten while stalled");

  // a stalled cell stays in the processing stage
  a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r && !s1_fire |=> s1_v_r && $stable(s1_col_r) && $stable(s1_row_r))
    else $error("processing stage lost a stalled cell");

  // read and write of the line buffer meet only at column zero
  a_line_hazard: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && in_accept && (col_r == s1_col_r) |-> col_r == '0)
    else $error("line buffer read collides with pending write");

  // tracking starts over after each grid
  a_grid_clear: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && s1_last_r |=> max_side_r == '0 && left_r == '0 && diag_r == '0)
    else $error("tracking not cleared after end of grid");

endmodule
